// ===== rtl/glyph_row_blitter_macros.svh =====
// ----------------------------------------------------------------------------
// glyph row blitter assertion macros
// shared concurrent assertion forms for the blitter modules
// ----------------------------------------------------------------------------
`ifndef GLYPH_ROW_BLITTER_MACROS_SVH
`define GLYPH_ROW_BLITTER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define GRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glyph_row_blitter: assertion failed");

// next-cycle implication
`define GRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glyph_row_blitter: assertion failed");

`else

`define GRB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/grb_pkg.sv =====
// ----------------------------------------------------------------------------
// grb_pkg
// shared types and constants of the glyph row blitter
// ----------------------------------------------------------------------------
package grb_pkg;

  localparam int PIXEL_BITS    = 32;
  localparam int MAX_GLYPH_DIM = 32;

  localparam logic [31:0] VALUE_MASK =
    (PIXEL_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PIXEL_BITS) - 64'd1);

  // msb of the row pattern holds column 0
  localparam logic [4:0] PAT_MSB = 5'd31;

  // color enable bits
  localparam int CE_INK   = 0;
  localparam int CE_PAPER = 1;

  typedef enum logic [2:0] {
    CFG_GLYPH_WIDTH   = 3'd0,
    CFG_GLYPH_HEIGHT  = 3'd1,
    CFG_FRAME_WIDTH   = 3'd2,
    CFG_FRAME_HEIGHT  = 3'd3,
    CFG_FRAME_PITCH   = 3'd4,
    CFG_INK_COLOR     = 3'd5,
    CFG_PAPER_COLOR   = 3'd6,
    CFG_COLOR_ENABLES = 3'd7
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic check;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_last;
  } sts_t;

endpackage

// ===== rtl/glyph_row_blitter.sv =====
// ----------------------------------------------------------------------------
// glyph_row_blitter: one glyph row in, one pixel write per selected column out
// sequence: accept, a check state (validation and row address multiply), then
// one result per cycle while the output does not stall; the input stays stalled until
// the last result of an item is issued (one result for an error or unselected row)
// reset: synchronous active-low, idle with no result pending, registers to defaults
// ----------------------------------------------------------------------------
module glyph_row_blitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_row_pattern,
  input  logic [4:0]  in_source_row,
  input  logic [4:0]  in_col_first,
  input  logic [4:0]  in_col_last,
  input  logic [4:0]  in_row_first,
  input  logic [4:0]  in_row_last,
  input  logic [11:0] in_dest_x,
  input  logic [11:0] in_dest_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_pixel_address,
  output logic [31:0] out_pixel_value,
  output logic        out_write_enable,
  output logic        out_request_error,
  output logic        out_last_of_row
);

  grb_pkg::cmd_t cmd;
  grb_pkg::sts_t sts;

  grb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  grb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_row_pattern    (in_row_pattern),
    .in_source_row     (in_source_row),
    .in_col_first      (in_col_first),
    .in_col_last       (in_col_last),
    .in_row_first      (in_row_first),
    .in_row_last       (in_row_last),
    .in_dest_x         (in_dest_x),
    .in_dest_y         (in_dest_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_write_enable  (out_write_enable),
    .out_request_error (out_request_error),
    .out_last_of_row   (out_last_of_row)
  );

endmodule

// ===== rtl/grb_ctrl.sv =====
// ----------------------------------------------------------------------------
// grb_ctrl
// sequencer for the glyph row blitter: accept, check, emit, and output valid
// ----------------------------------------------------------------------------
`include "glyph_row_blitter_macros.svh"

module grb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  grb_pkg::sts_t sts,
  output grb_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.load_in = (state_r == S_IDLE) && in_valid;
    cmd.check   = (state_r == S_CHECK);
    cmd.emit    = (state_r == S_EMIT) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free && sts.emit_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `GRB_ASSERT_NEXT(a_accept_to_check, clk, rst_n, in_valid && !in_stall, state_r == S_CHECK)
  `GRB_ASSERT_NEXT(a_check_to_emit, clk, rst_n, state_r == S_CHECK, state_r == S_EMIT)
  `GRB_ASSERT_NEXT(a_last_to_idle, clk, rst_n, cmd.emit && sts.emit_last, state_r == S_IDLE)
  `GRB_ASSERT_IMPL(a_valid_from_emit, clk, rst_n, $rose(out_valid_r), $past(cmd.emit))

endmodule

// ===== rtl/grb_dp.sv =====
// ----------------------------------------------------------------------------
// grb_dp
// datapath of the glyph row blitter: registers, validation, address and color
// ----------------------------------------------------------------------------
module grb_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  grb_pkg::cmd_t cmd,
  output grb_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  input  logic [31:0]   in_row_pattern,
  input  logic [4:0]    in_source_row,
  input  logic [4:0]    in_col_first,
  input  logic [4:0]    in_col_last,
  input  logic [4:0]    in_row_first,
  input  logic [4:0]    in_row_last,
  input  logic [11:0]   in_dest_x,
  input  logic [11:0]   in_dest_y,
  output logic [23:0]   out_pixel_address,
  output logic [31:0]   out_pixel_value,
  output logic          out_write_enable,
  output logic          out_request_error,
  output logic          out_last_of_row
);

  // configuration registers
  logic [5:0]  gw_r, gh_r;
  logic [12:0] fw_r, fh_r, pitch_r;
  logic [31:0] ink_r, paper_r;
  logic [1:0]  ce_r;

  // latched transaction
  logic [31:0] pat_r;
  logic [4:0]  srow_r, c0_r, c1_r, r0_r, r1_r;
  logic [11:0] x_r, y_r;

  // check results and walk state
  logic        bad_r, skip_r;
  logic [23:0] prod_r;
  logic [4:0]  j_r, col_r;

  // output register
  logic [23:0] addr_r;
  logic [31:0] val_r;
  logic        we_r, err_r, last_r;

  logic [4:0]  col_span, row_span, row_lo, row_hi, roff;
  logic [5:0]  ncols, nrows;
  logic [12:0] yrow;
  logic [25:0] prod;
  logic        bad, skip;
  logic        ink, en, last_pix;
  logic [31:0] color;
  logic [23:0] pix_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= 6'd8;
      gh_r    <= 6'd16;
      fw_r    <= 13'd640;
      fh_r    <= 13'd480;
      pitch_r <= 13'd640;
      ink_r   <= 32'hFFFF_FFFF;
      paper_r <= 32'h0;
      ce_r    <= 2'b11;
    end else if (cfg_we) begin
      case (grb_pkg::cfg_idx_t'(cfg_index))
        grb_pkg::CFG_GLYPH_WIDTH:   gw_r    <= cfg_wdata[5:0];
        grb_pkg::CFG_GLYPH_HEIGHT:  gh_r    <= cfg_wdata[5:0];
        grb_pkg::CFG_FRAME_WIDTH:   fw_r    <= cfg_wdata[12:0];
        grb_pkg::CFG_FRAME_HEIGHT:  fh_r    <= cfg_wdata[12:0];
        grb_pkg::CFG_FRAME_PITCH:   pitch_r <= cfg_wdata[12:0];
        grb_pkg::CFG_INK_COLOR:     ink_r   <= cfg_wdata;
        grb_pkg::CFG_PAPER_COLOR:   paper_r <= cfg_wdata;
        grb_pkg::CFG_COLOR_ENABLES: ce_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pat_r  <= in_row_pattern;
      srow_r <= in_source_row;
      c0_r   <= in_col_first;
      c1_r   <= in_col_last;
      r0_r   <= in_row_first;
      r1_r   <= in_row_last;
      x_r    <= in_dest_x;
      y_r    <= in_dest_y;
    end
  end

  // validation and row selection
  always_comb begin
    col_span = (c0_r <= c1_r) ? (c1_r - c0_r) : (c0_r - c1_r);
    row_span = (r0_r <= r1_r) ? (r1_r - r0_r) : (r0_r - r1_r);
    ncols    = {1'b0, col_span} + 6'd1;
    nrows    = {1'b0, row_span} + 6'd1;
    row_lo   = (r0_r < r1_r) ? r0_r : r1_r;
    row_hi   = (r0_r < r1_r) ? r1_r : r0_r;
    roff     = (r0_r <= srow_r) ? (srow_r - r0_r) : (r0_r - srow_r);

    bad = (gw_r == 6'd0) || (gh_r == 6'd0) ||
          ({1'b0, gw_r} > 7'(grb_pkg::MAX_GLYPH_DIM)) ||
          ({1'b0, gh_r} > 7'(grb_pkg::MAX_GLYPH_DIM)) ||
          ({1'b0, c0_r} >= gw_r) || ({1'b0, c1_r} >= gw_r) ||
          ({1'b0, r0_r} >= gh_r) || ({1'b0, r1_r} >= gh_r) ||
          (fw_r == 13'd0) || (fh_r == 13'd0) ||
          (pitch_r < fw_r) ||
          ({1'b0, x_r} >= fw_r) || ({1'b0, y_r} >= fh_r) ||
          (ce_r == 2'b00) ||
          ((13'(x_r) + 13'(ncols)) > fw_r) ||
          ((13'(y_r) + 13'(nrows)) > fh_r);

    skip = (srow_r < row_lo) || (srow_r > row_hi);

    yrow = 13'(y_r) + 13'(roff);
    prod = yrow * pitch_r;
  end

  // pixel of the current column
  always_comb begin
    ink      = pat_r[grb_pkg::PAT_MSB - col_r];
    en       = ink ? ce_r[grb_pkg::CE_INK] : ce_r[grb_pkg::CE_PAPER];
    color    = (ink ? ink_r : paper_r) & grb_pkg::VALUE_MASK;
    last_pix = (j_r == col_span);
    pix_addr = prod_r + 24'(x_r) + 24'(j_r);
  end

  assign sts.emit_last = bad_r || skip_r || last_pix;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      bad_r  <= bad;
      skip_r <= skip;
      prod_r <= prod[23:0];
      j_r    <= 5'd0;
      col_r  <= c0_r;
    end else if (cmd.emit) begin
      j_r   <= j_r + 5'd1;
      col_r <= (c0_r <= c1_r) ? (col_r + 5'd1) : (col_r - 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (bad_r) begin
        addr_r <= 24'd0;
        val_r  <= 32'd0;
        we_r   <= 1'b0;
        err_r  <= 1'b1;
        last_r <= 1'b1;
      end else if (skip_r) begin
        addr_r <= 24'd0;
        val_r  <= 32'd0;
        we_r   <= 1'b0;
        err_r  <= 1'b0;
        last_r <= 1'b1;
      end else begin
        addr_r <= pix_addr;
        val_r  <= en ? color : 32'd0;
        we_r   <= en;
        err_r  <= 1'b0;
        last_r <= last_pix;
      end
    end
  end

  assign out_pixel_address = addr_r;
  assign out_pixel_value   = val_r;
  assign out_write_enable  = we_r;
  assign out_request_error = err_r;
  assign out_last_of_row   = last_r;

endmodule

// ===== test/tb_glyph_row_blitter.sv =====
// ----------------------------------------------------------------------------
// tb_glyph_row_blitter
// self-checking test of the glyph row blitter: a directed list of requests and
// register settings, then randomized phases under several idle and stall patterns; every
// pixel write is compared against a behavioral expansion of the request
// ----------------------------------------------------------------------------
module tb_glyph_row_blitter;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pattern;
    logic [4:0]  src_row;
    logic [4:0]  col_a;
    logic [4:0]  col_b;
    logic [4:0]  row_a;
    logic [4:0]  row_b;
    logic [11:0] dx;
    logic [11:0] dy;
  } glyph_req_t;

  typedef struct packed {
    logic [23:0] addr;
    logic [31:0] value;
    logic        we;
    logic        err;
    logic        last;
  } pixel_write_t;

  typedef enum logic {STEP_REQ, STEP_REG} step_op_t;
  typedef enum logic [1:0] {WANT_MODEL, WANT_REJECT, WANT_SKIP} step_want_t;

  typedef struct packed {
    step_op_t          op;
    step_want_t        want;
    grb_pkg::cfg_idx_t reg_idx;
    logic [31:0]       reg_val;
    glyph_req_t        req;
  } plan_step_t;

  localparam pixel_write_t REJECTED_ROW = '{24'd0, 32'd0, 1'b0, 1'b1, 1'b1};
  localparam pixel_write_t SKIPPED_ROW  = '{24'd0, 32'd0, 1'b0, 1'b0, 1'b1};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_row_pattern;
  logic [4:0]  in_source_row;
  logic [4:0]  in_col_first;
  logic [4:0]  in_col_last;
  logic [4:0]  in_row_first;
  logic [4:0]  in_row_last;
  logic [11:0] in_dest_x;
  logic [11:0] in_dest_y;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] out_pixel_address;
  logic [31:0] out_pixel_value;
  logic        out_write_enable;
  logic        out_request_error;
  logic        out_last_of_row;

  // register shadows
  int unsigned glyph_w, glyph_h, fb_w, fb_h, fb_pitch, color_en;
  logic [31:0] ink_px, paper_px;

  pixel_write_t pending_writes[$];
  plan_step_t   plan[$];

  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned writes_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned reqs_sent = 0;
  int unsigned reg_writes = 0;

  glyph_row_blitter u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic note_mismatch(input string what, input pixel_write_t want,
                               input pixel_write_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s: expected addr=%h val=%h we=%b err=%b last=%b", what,
               want.addr, want.value, want.we, want.err, want.last);
      $display("    actual   addr=%h val=%h we=%b err=%b last=%b",
               got.addr, got.value, got.we, got.err, got.last);
    end
  endtask

  // outputs settle long before the falling edge; a transaction seen here is
  // taken at the next rising edge
  always @(negedge clk) begin
    pixel_write_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pixel_address, out_pixel_value, out_write_enable,
              out_request_error, out_last_of_row};
      writes_seen++;
      if (got.err === 1'b1)
        rejects_seen++;
      if (pending_writes.size() == 0) begin
        note_mismatch("unexpected pixel write", '0, got);
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr || got.value !== want.value ||
            got.we !== want.we || got.err !== want.err || got.last !== want.last)
          note_mismatch("pixel write mismatch", want, got);
      end
    end
  end

  // expand one request into the pixel writes it must produce
  function automatic void blit_row(input glyph_req_t r);
    int unsigned c0, c1, r0, r1, s, x, y, span_c, span_r, lo, hi, roff, base;
    int col;
    logic bad, ink, en;
    pixel_write_t w;
    c0 = r.col_a;
    c1 = r.col_b;
    r0 = r.row_a;
    r1 = r.row_b;
    s = r.src_row;
    x = r.dx;
    y = r.dy;
    span_c = (c0 <= c1) ? c1 - c0 + 1 : c0 - c1 + 1;
    span_r = (r0 <= r1) ? r1 - r0 + 1 : r0 - r1 + 1;
    bad = glyph_w == 0 || glyph_h == 0 || glyph_w > grb_pkg::MAX_GLYPH_DIM ||
          glyph_h > grb_pkg::MAX_GLYPH_DIM || c0 >= glyph_w || c1 >= glyph_w ||
          r0 >= glyph_h || r1 >= glyph_h || fb_w == 0 || fb_h == 0 ||
          fb_pitch < fb_w || x >= fb_w || y >= fb_h || color_en == 0 ||
          x + span_c > fb_w || y + span_r > fb_h;
    if (bad) begin
      pending_writes.push_back(REJECTED_ROW);
      return;
    end
    lo = (r0 < r1) ? r0 : r1;
    hi = (r0 < r1) ? r1 : r0;
    if (s < lo || s > hi) begin
      pending_writes.push_back(SKIPPED_ROW);
      return;
    end
    roff = (r0 <= s) ? s - r0 : r0 - s;
    base = (y + roff) * fb_pitch + x;
    col = int'(c0);
    for (int unsigned j = 0; j < span_c; j++) begin
      ink = r.pattern[31 - col];
      en = ink ? color_en[grb_pkg::CE_INK] : color_en[grb_pkg::CE_PAPER];
      w.addr = 24'(base + j);
      w.value = en ? ((ink ? ink_px : paper_px) & grb_pkg::VALUE_MASK) : 32'd0;
      w.we = en;
      w.err = 1'b0;
      w.last = (j + 1 == span_c);
      pending_writes.push_back(w);
      col = (c0 <= c1) ? col + 1 : col - 1;
    end
  endfunction

  task automatic drive_row(input glyph_req_t r);
    logic taken;
    cfg_we <= 1'b0;
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_row_pattern <= r.pattern;
    in_source_row  <= r.src_row;
    in_col_first   <= r.col_a;
    in_col_last    <= r.col_b;
    in_row_first   <= r.row_a;
    in_row_last    <= r.row_b;
    in_dest_x      <= r.dx;
    in_dest_y      <= r.dy;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    reqs_sent++;
  endtask

  // stop sending and wait until every pending write has come out
  task automatic drain();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    do
      @(posedge clk);
    while (pending_writes.size() != 0);
  endtask

  task automatic reg_write(input grb_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      grb_pkg::CFG_GLYPH_WIDTH:   glyph_w  = val & 32'h3F;
      grb_pkg::CFG_GLYPH_HEIGHT:  glyph_h  = val & 32'h3F;
      grb_pkg::CFG_FRAME_WIDTH:   fb_w     = val & 32'h1FFF;
      grb_pkg::CFG_FRAME_HEIGHT:  fb_h     = val & 32'h1FFF;
      grb_pkg::CFG_FRAME_PITCH:   fb_pitch = val & 32'h1FFF;
      grb_pkg::CFG_INK_COLOR:     ink_px   = val;
      grb_pkg::CFG_PAPER_COLOR:   paper_px = val;
      grb_pkg::CFG_COLOR_ENABLES: color_en = val & 32'h3;
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic plan_step_t req_step(input step_want_t want, input logic [31:0] pat,
                                          input int s, input int ca, input int cb,
                                          input int ra, input int rb, input int x,
                                          input int y);
    plan_step_t p;
    p = '0;
    p.op = STEP_REQ;
    p.want = want;
    p.req = '{pat, 5'(s), 5'(ca), 5'(cb), 5'(ra), 5'(rb), 12'(x), 12'(y)};
    return p;
  endfunction

  function automatic plan_step_t reg_step(input grb_pkg::cfg_idx_t idx,
                                          input logic [31:0] val);
    plan_step_t p;
    p = '0;
    p.op = STEP_REG;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    glyph_req_t req;
    int unsigned span_c, span_r, lo, hi, directed_cnt;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= grb_pkg::CFG_GLYPH_WIDTH;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_row_pattern <= '0;
    in_source_row  <= '0;
    in_col_first   <= '0;
    in_col_last    <= '0;
    in_row_first   <= '0;
    in_row_last    <= '0;
    in_dest_x      <= '0;
    in_dest_y      <= '0;
    glyph_w  = 8;
    glyph_h  = 16;
    fb_w     = 640;
    fb_h     = 480;
    fb_pitch = 640;
    ink_px   = 32'hFFFF_FFFF;
    paper_px = 32'h0;
    color_en = 3;

    // defaults after reset first, then limits of the registers
    plan.push_back(req_step(WANT_MODEL,  32'hA500_0000, 0, 0, 7, 0, 0, 0, 0));
    plan.push_back(req_step(WANT_MODEL,  32'h3C81_0000, 3, 7, 0, 5, 2, 10, 20));
    plan.push_back(req_step(WANT_SKIP,   32'hFFFF_FFFF, 10, 0, 7, 2, 4, 100, 100));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 8, 0, 0, 0, 0, 0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 16, 0, 0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 640, 0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 480));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 7, 0, 0, 635, 0));
    plan.push_back(req_step(WANT_MODEL,  32'hFFFF_FFFF, 0, 0, 7, 0, 0, 632, 479));
    plan.push_back(req_step(WANT_REJECT, 32'h0, 1, 0, 0, 0, 2, 0, 478));
    plan.push_back(reg_step(grb_pkg::CFG_COLOR_ENABLES, 32'd0));
    plan.push_back(req_step(WANT_REJECT, 32'hF0F0_0000, 0, 0, 7, 0, 0, 0, 0));
    plan.push_back(reg_step(grb_pkg::CFG_INK_COLOR, 32'h1234_5678));
    plan.push_back(reg_step(grb_pkg::CFG_COLOR_ENABLES, 32'd1));
    plan.push_back(req_step(WANT_MODEL,  32'hAA00_0000, 0, 0, 7, 0, 0, 3, 3));
    plan.push_back(reg_step(grb_pkg::CFG_PAPER_COLOR, 32'hDEAD_BEEF));
    plan.push_back(reg_step(grb_pkg::CFG_COLOR_ENABLES, 32'd2));
    plan.push_back(req_step(WANT_MODEL,  32'hAA00_0000, 0, 7, 0, 0, 0, 3, 3));
    plan.push_back(reg_step(grb_pkg::CFG_GLYPH_WIDTH, 32'd0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(reg_step(grb_pkg::CFG_GLYPH_WIDTH, 32'd63));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(reg_step(grb_pkg::CFG_GLYPH_WIDTH, 32'd32));
    plan.push_back(reg_step(grb_pkg::CFG_GLYPH_HEIGHT, 32'd32));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_WIDTH, 32'd4096));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_HEIGHT, 32'd4096));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_PITCH, 32'd4096));
    plan.push_back(reg_step(grb_pkg::CFG_COLOR_ENABLES, 32'd3));
    plan.push_back(reg_step(grb_pkg::CFG_INK_COLOR, 32'hFFFF_FFFF));
    plan.push_back(reg_step(grb_pkg::CFG_PAPER_COLOR, 32'h0));
    plan.push_back(req_step(WANT_MODEL,  32'hFFFF_FFFF, 31, 0, 31, 31, 0, 0, 4064));
    plan.push_back(req_step(WANT_MODEL,  32'h0, 0, 31, 0, 0, 31, 4064, 0));
    plan.push_back(req_step(WANT_MODEL,  32'h0000_0001, 31, 31, 31, 31, 31, 4095, 4095));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_WIDTH, 32'd0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_WIDTH, 32'd4096));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_HEIGHT, 32'd0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_HEIGHT, 32'd4096));
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_PITCH, 32'd4095));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    // pitch beyond the frame pushes the address past 24 bits
    plan.push_back(reg_step(grb_pkg::CFG_FRAME_PITCH, 32'd8191));
    plan.push_back(req_step(WANT_MODEL,  32'h5A5A_5A5A, 7, 3, 20, 0, 15, 100, 4000));
    plan.push_back(reg_step(grb_pkg::CFG_GLYPH_HEIGHT, 32'd0));
    plan.push_back(req_step(WANT_REJECT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    foreach (plan[i]) begin
      if (plan[i].op == STEP_REG) begin
        drain();
        reg_write(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        case (plan[i].want)
          WANT_REJECT: pending_writes.push_back(REJECTED_ROW);
          WANT_SKIP:   pending_writes.push_back(SKIPPED_ROW);
          default:     blit_row(plan[i].req);
        endcase
        drive_row(plan[i].req);
      end
    end
    directed_cnt = reqs_sent;

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 69; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 69; end
        default: begin send_pct = 17; stall_pct = 17; end
      endcase
      reg_write(grb_pkg::CFG_GLYPH_WIDTH, $urandom_range(1, grb_pkg::MAX_GLYPH_DIM));
      reg_write(grb_pkg::CFG_GLYPH_HEIGHT, $urandom_range(1, grb_pkg::MAX_GLYPH_DIM));
      reg_write(grb_pkg::CFG_FRAME_WIDTH,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096));
      reg_write(grb_pkg::CFG_FRAME_HEIGHT,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096));
      reg_write(grb_pkg::CFG_FRAME_PITCH,
                $urandom_range(0, 1) ? fb_w : $urandom_range(fb_w, 8191));
      reg_write(grb_pkg::CFG_INK_COLOR, $urandom);
      reg_write(grb_pkg::CFG_PAPER_COLOR, $urandom);
      reg_write(grb_pkg::CFG_COLOR_ENABLES, $urandom_range(1, 3));

      for (int k = 0; k < 18; k++) begin
        if (k == 10)
          drain();
        req.pattern = $urandom;
        if ($urandom_range(0, 99) < 85) begin
          // request inside the glyph and, where the span fits, the frame; row mostly inside the range
          req.col_a = 5'($urandom_range(0, glyph_w - 1));
          req.col_b = 5'($urandom_range(0, glyph_w - 1));
          req.row_a = 5'($urandom_range(0, glyph_h - 1));
          req.row_b = 5'($urandom_range(0, glyph_h - 1));
          span_c = (req.col_a <= req.col_b) ? req.col_b - req.col_a + 1
                                            : req.col_a - req.col_b + 1;
          span_r = (req.row_a <= req.row_b) ? req.row_b - req.row_a + 1
                                            : req.row_a - req.row_b + 1;
          req.dx = 12'((span_c <= fb_w) ? $urandom_range(0, fb_w - span_c)
                                        : $urandom_range(0, 4095));
          req.dy = 12'((span_r <= fb_h) ? $urandom_range(0, fb_h - span_r)
                                        : $urandom_range(0, 4095));
          lo = (req.row_a < req.row_b) ? req.row_a : req.row_b;
          hi = (req.row_a < req.row_b) ? req.row_b : req.row_a;
          req.src_row = 5'(($urandom_range(0, 99) < 80) ? $urandom_range(lo, hi)
                                                        : $urandom_range(0, 31));
        end else begin
          req.src_row = 5'($urandom);
          req.col_a   = 5'($urandom);
          req.col_b   = 5'($urandom);
          req.row_a   = 5'($urandom);
          req.row_b   = 5'($urandom);
          req.dx      = 12'($urandom);
          req.dy      = 12'($urandom);
        end
        blit_row(req);
        drive_row(req);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("sent %0d requests (%0d directed) over %0d register writes", reqs_sent,
             directed_cnt, reg_writes);
    $display("checked %0d pixel transactions, %0d rejections, idle and stall mixes",
             writes_seen, rejects_seen);
    if (mismatch_cnt == 0 && pending_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d writes never seen", mismatch_cnt, pending_writes.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
